[hw/rtl/modular_exponentiation_top_macros.svh]
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MME_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define MME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hw/rtl/mme_pkg.sv]
// Types and constants for the modular exponentiation block.
// No dependencies; used by every module of the block.
package mme_pkg;

   localparam int unsigned MME_RES_W = 30;
   localparam logic [MME_RES_W-1:0] MME_MOD = 30'd1000000007;

   typedef enum logic {
      MME_TAG_SQ,
      MME_TAG_ACC
   } mme_tag_type;

   typedef struct packed {
      logic                 valid;
      mme_tag_type          tag;
      logic [MME_RES_W-1:0] a;
      logic [MME_RES_W-1:0] b;
      logic [MME_RES_W-1:0] r;
   } mme_cell_type;

   typedef enum logic [2:0] {
      MME_S_IDLE,
      MME_S_ISSUE_SQ,
      MME_S_ISSUE_ACC,
      MME_S_WAIT,
      MME_S_DONE
   } mme_state_type;

endpackage

[hw/rtl/modular_exponentiation_top.sv]
// Top level: base^exponent mod 1000000007, right-to-left square-and-multiply.
// Depends on mme_pkg, mme_chain, modular_exponentiation_top_macros.svh.
//
//   channel | direction | ports                             | item
//   req     | in        | req_valid req_stall req_base/exp  | one base, one exponent
//   rsp     | out       | rsp_valid rsp_stall rsp_power_mod | one residue
//
// Every product goes through a row of 30 registered cells (one multiplier bit
// each). Square and optional multiply enter on back-to-back cycles; the next
// exponent bit starts once the last product of this bit is back. Scanning stops
// at the highest set bit, and a zero exponent goes straight to the result.
// Reset (synchronous) clears the sequencer and valid flags only.
// req_stall is high while an item is in work; a stalled result sits in the
// output register and the next item is still taken.
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top #(
   parameter int unsigned EXP_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_base,
   input  logic [31:0] req_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [29:0] rsp_power_mod
);

   localparam logic [31:0] MOD32 = {2'b00, mme_pkg::MME_MOD};

   mme_pkg::mme_state_type state_ff, state_in;
   logic [mme_pkg::MME_RES_W-1:0] sq_ff, sq_in;
   logic [mme_pkg::MME_RES_W-1:0] acc_ff, acc_in;
   logic [EXP_BITS-1:0]           exp_ff, exp_in;
   mme_pkg::mme_tag_type          last_tag_ff, last_tag_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mme_pkg::MME_RES_W-1:0] rsp_power_mod_ff, rsp_power_mod_in;

   mme_pkg::mme_cell_type chain_in, chain_out;

   logic [31:0] base_w, base_sub1_w, base_sub2_w;
   logic        bit_done_w;   // last product of this exponent bit is back
   logic        rsp_free_w;   // output register can take a new item

   // base < 2^31 < 3P: two conditional subtracts reduce it
   always_comb begin
      base_w      = {1'b0, req_base};
      base_sub1_w = (base_w >= MOD32) ? (base_w - MOD32) : base_w;
      base_sub2_w = (base_sub1_w >= MOD32) ? (base_sub1_w - MOD32) : base_sub1_w;
   end

   assign bit_done_w = chain_out.valid && (chain_out.tag == last_tag_ff);
   assign rsp_free_w = !rsp_valid_ff || !rsp_stall;

   mme_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .chain_in  (chain_in),
      .chain_out (chain_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mme_pkg::MME_S_IDLE: begin
            if (req_valid) state_in = mme_pkg::MME_S_ISSUE_SQ;
         end
         mme_pkg::MME_S_ISSUE_SQ: begin
            state_in = (exp_ff == '0) ? mme_pkg::MME_S_DONE : mme_pkg::MME_S_ISSUE_ACC;
         end
         mme_pkg::MME_S_ISSUE_ACC: begin
            state_in = mme_pkg::MME_S_WAIT;
         end
         mme_pkg::MME_S_WAIT: begin
            if (bit_done_w) state_in = mme_pkg::MME_S_ISSUE_SQ;
         end
         mme_pkg::MME_S_DONE: begin
            if (rsp_free_w) state_in = mme_pkg::MME_S_IDLE;
         end
         default: begin
            state_in = mme_pkg::MME_S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      sq_in            = sq_ff;
      acc_in           = acc_ff;
      exp_in           = exp_ff;
      last_tag_in      = last_tag_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_power_mod_in = rsp_power_mod_ff;
      chain_in         = '0;
      req_stall        = (state_ff != mme_pkg::MME_S_IDLE);
      case (state_ff)
         mme_pkg::MME_S_IDLE: begin
            if (req_valid) begin
               sq_in  = base_sub2_w[mme_pkg::MME_RES_W-1:0];
               acc_in = mme_pkg::MME_RES_W'(1);
               exp_in = EXP_BITS'(req_exponent);
            end
         end
         mme_pkg::MME_S_ISSUE_SQ: begin
            if (exp_ff != '0) begin
               chain_in.valid = 1'b1;
               chain_in.tag   = mme_pkg::MME_TAG_SQ;
               chain_in.a     = sq_ff;
               chain_in.b     = sq_ff;
               last_tag_in    = mme_pkg::MME_TAG_SQ;
            end
         end
         mme_pkg::MME_S_ISSUE_ACC: begin
            // square in flight still uses the old sq; the multiply does too
            if (exp_ff[0]) begin
               chain_in.valid = 1'b1;
               chain_in.tag   = mme_pkg::MME_TAG_ACC;
               chain_in.a     = acc_ff;
               chain_in.b     = sq_ff;
               last_tag_in    = mme_pkg::MME_TAG_ACC;
            end
         end
         mme_pkg::MME_S_WAIT: begin
            if (chain_out.valid) begin
               if (chain_out.tag == mme_pkg::MME_TAG_SQ) sq_in = chain_out.r;
               else acc_in = chain_out.r;
            end
            if (bit_done_w) exp_in = exp_ff >> 1;
         end
         mme_pkg::MME_S_DONE: begin
            if (rsp_free_w) begin
               rsp_valid_in     = 1'b1;
               rsp_power_mod_in = acc_ff;
            end
         end
         default: begin
            chain_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sq_ff            <= sq_in;
      acc_ff           <= acc_in;
      exp_ff           <= exp_in;
      last_tag_ff      <= last_tag_in;
      rsp_power_mod_ff <= rsp_power_mod_in;
      if (reset) begin
         state_ff     <= mme_pkg::MME_S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = rsp_power_mod_ff;

   `MME_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall,
      state_ff == mme_pkg::MME_S_ISSUE_SQ)
   `MME_ASSERT_IMPL(a_return_in_wait, clock, reset, chain_out.valid,
      state_ff == mme_pkg::MME_S_WAIT)
   `MME_ASSERT_IMPL(a_state_reduced, clock, reset, state_ff != mme_pkg::MME_S_IDLE,
      (sq_ff < mme_pkg::MME_MOD) && (acc_ff < mme_pkg::MME_MOD))
   `MME_ASSERT_IMPL(a_result_reduced, clock, reset, rsp_valid_ff,
      rsp_power_mod_ff < mme_pkg::MME_MOD)

endmodule

[hw/rtl/mme_cell.sv]
// One cell of the modular multiplier row: r = (2r + a*b_msb) mod P.
// Depends on mme_pkg.
module mme_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  mme_pkg::mme_cell_type cell_in,
   output mme_pkg::mme_cell_type cell_out
);

   localparam logic [31:0] MOD32 = {2'b00, mme_pkg::MME_MOD};

   mme_pkg::mme_cell_type cell_ff, cell_in_w;
   logic [31:0] sum_w, sub1_w, sub2_w;

   always_comb begin
      sum_w  = {1'b0, cell_in.r, 1'b0}
             + (cell_in.b[mme_pkg::MME_RES_W-1] ? {2'b00, cell_in.a} : 32'd0);
      sub1_w = (sum_w >= MOD32) ? (sum_w - MOD32) : sum_w;
      sub2_w = (sub1_w >= MOD32) ? (sub1_w - MOD32) : sub1_w;
      cell_in_w   = cell_in;
      cell_in_w.b = {cell_in.b[mme_pkg::MME_RES_W-2:0], 1'b0};
      cell_in_w.r = sub2_w[mme_pkg::MME_RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_w;
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign cell_out = cell_ff;

endmodule

[hw/rtl/mme_chain.sv]
// Row of multiplier cells, one per residue bit, scanned MSB first.
// Depends on mme_pkg and mme_cell.
module mme_chain (
   input  logic                 clock,
   input  logic                 reset,
   input  mme_pkg::mme_cell_type chain_in,
   output mme_pkg::mme_cell_type chain_out
);

   mme_pkg::mme_cell_type link_w [mme_pkg::MME_RES_W+1];

   assign link_w[0] = chain_in;

   for (genvar g = 0; g < mme_pkg::MME_RES_W; g++) begin : g_cell
      mme_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (link_w[g]),
         .cell_out (link_w[g+1])
      );
   end

   assign chain_out = link_w[mme_pkg::MME_RES_W];

endmodule

[tb/sv/modular_exponentiation_top_tb.sv]
// Testbench for modular_exponentiation_top: base^exponent mod 1000000007.
// Drives random and directed items, predicts each residue locally and checks
// every result in order. Depends on the block's RTL only.
`timescale 1ns / 100ps

module modular_exponentiation_top_tb;

   localparam longint unsigned PRIME = 64'd1000000007;
   localparam int unsigned     LIMIT_CYCLES = 3000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [30:0] req_base;
   logic [31:0] req_exponent;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [29:0] rsp_power_mod;

   logic [29:0] residue_queue[$];
   int          error_count;
   int unsigned cycle_count;
   bit          stall_enable;

   modular_exponentiation_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_base(req_base),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_power_mod(rsp_power_mod)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Right-to-left square-and-multiply over all 32 exponent bits.
   function automatic logic [29:0] power_mod_of(logic [30:0] base, logic [31:0] exponent);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1;
      sq = base % PRIME;
      for (int i = 0; i < 32; i++) begin
         if (exponent[i]) acc = (acc * sq) % PRIME;
         sq = (sq * sq) % PRIME;
      end
      return acc[29:0];
   endfunction

   task automatic report_mismatch(string what, logic [29:0] got, logic [29:0] want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Sends one item after a random gap when stalls are enabled; the prediction is queued on acceptance.
   // Valid stays high after acceptance until the next gap or the drain drops it.
   task automatic send_item(logic [30:0] base, logic [31:0] exponent);
      int gap;
      gap = stall_enable ? $urandom_range(16, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (req_stall);
      residue_queue = {residue_queue, power_mod_of(base, exponent)};
   endtask

   // Result checker: compares each accepted residue with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (residue_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_power_mod, 30'd0);
         end else begin
            logic [29:0] want;
            want = residue_queue.pop_front();
            if (rsp_power_mod !== want) report_mismatch("power_mod", rsp_power_mod, want);
         end
      end
   end

   // Receiver stall: a random hold per result, sometimes none at all.
   int stall_left;
   always @(posedge clock) begin
      if (reset || !stall_enable) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left <= $urandom_range(16, 0);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(31'd0, 32'd0);               // zero exponent, zero base
      send_item(31'd1000000007, 32'd0);      // base equal to the prime, zero exp
      send_item(31'd0, 32'd5);
      send_item(31'd1, 32'hFFFF_FFFF);
      send_item(31'h7FFF_FFFF, 32'hFFFF_FFFF); // widest fields
      send_item(31'h7FFF_FFFF, 32'd1);
      send_item(31'd1000000007, 32'd3);      // reduces to zero
      send_item(31'd1000000008, 32'd12345);  // above the prime
      send_item(31'd1000000006, 32'd2);
      send_item(31'd2, 32'd1000000005);      // inverse via Fermat
      send_item(31'd2, 32'h8000_0000);
      send_item(31'd3, 32'd1);
      send_item(31'h5555_5555, 32'hAAAA_AAAA);
      send_item(31'h2AAA_AAAA, 32'h5555_5555);
   endtask

   task automatic test_random(int count);
      logic [31:0] e;
      for (int n = 0; n < count; n++) begin
         // Mostly short exponents keep the run brief; a few span all bits.
         case ($urandom_range(9, 0))
            0, 1:    e = $urandom;
            2:       e = $urandom_range(1, 0);
            default: e = $urandom >> $urandom_range(31, 16);
         endcase
         send_item(31'($urandom), e);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (residue_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_base = '0;
      req_exponent = '0;
      stall_enable = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100);          // back-to-back, no idling
      stall_enable = 1'b1;
      test_random(650);
      drain();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mme_pkg.sv
hw/rtl/mme_cell.sv
hw/rtl/mme_chain.sv
hw/rtl/modular_exponentiation_top.sv
tb/sv/modular_exponentiation_top_tb.sv
